// File: hw/rtl/owrs_pkg.sv
package owrs_pkg;

    // Item kinds carried in s_tuser.
    localparam logic [1:0] FUNC_NEW_SEARCH = 2'd0;
    localparam logic [1:0] FUNC_START_PASS = 2'd1;
    localparam logic [1:0] FUNC_BIT_PAIR   = 2'd2;

    // Result status codes carried in m_tuser.
    localparam logic [2:0] ST_CONTINUE    = 3'd0;
    localparam logic [2:0] ST_FOUND       = 3'd1;
    localparam logic [2:0] ST_CRC_BAD     = 3'd2;
    localparam logic [2:0] ST_NO_PRESENCE = 3'd3;
    localparam logic [2:0] ST_CONFLICT    = 3'd4;
    localparam logic [2:0] ST_DONE        = 3'd5;
    localparam logic [2:0] ST_IGNORED     = 3'd6;

    // Reflected CRC-8 polynomial of the ROM code check.
    localparam logic [7:0] CRC_POLY = 8'h8C;

    localparam int FUNC_W    = 2;
    localparam int STATUS_W  = 3;
    localparam int ROM_W     = 64;
    localparam int FORK_W    = 8;
    localparam int S_DATA_W  = 8;
    localparam int M_DATA_W  = 80;

    typedef logic [FORK_W-1:0] fork_t;

endpackage

// File: hw/rtl/onewire_rom_search_engine_top.sv
// A result appears in the output register in the cycle after its input transfer.
// Throughput: one item per cycle; s_tready stays high while the output register is
// empty or is being drained in the same cycle.
// Reset (rst_n low, asynchronous): committed and working codes clear to zero, both
// forks load ROM_BITS, no pass is active and the output register is empty.
module onewire_rom_search_engine_top
    import owrs_pkg::*;
#(
    parameter int ROM_BITS = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // s_tdata from bit 0: first_bit, second_bit, presence, zero fill.
    input  logic [S_DATA_W-1:0] s_tdata,
    // s_tuser from bit 0: func.
    input  logic [FUNC_W-1:0]   s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // m_tdata from bit 0: drive_write, write_bit, rom_code[63:0],
    // fork_position[7:0], zero fill.
    output logic [M_DATA_W-1:0] m_tdata,
    // m_tuser from bit 0: status.
    output logic [STATUS_W-1:0] m_tuser
);

    localparam int IDX_W = (ROM_BITS > 1) ? $clog2(ROM_BITS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROM_BITS - 1);
    localparam fork_t FORK_INIT = FORK_W'(ROM_BITS);
    localparam fork_t FORK_NONE = '1;

    // Search state. The forks are two's complement; all ones means no fork left.
    logic [ROM_BITS-1:0] committed_rom_reg, committed_rom_next;
    fork_t               committed_fork_reg, committed_fork_next;
    logic [ROM_BITS-1:0] working_rom_reg, working_rom_next;
    fork_t               working_fork_reg, working_fork_next;
    logic [IDX_W-1:0]    bit_pos_reg, bit_pos_next;
    logic                pass_active_reg, pass_active_next;
    logic [7:0]          crc_reg, crc_next;

    // Output register.
    logic                m_valid_reg;
    logic                drive_reg, drive_next;
    logic                wbit_reg, wbit_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic                in_xfer;
    logic [FUNC_W-1:0]   func;
    logic                first_bit;
    logic                second_bit;
    logic                presence;

    logic [ROM_BITS-1:0] prep_rom;
    logic                pick_bit;
    logic                crc_fb;
    logic [7:0]          crc_step;

    // The output register is the only buffer; a new item may enter whenever it
    // is empty or its content leaves in this cycle.
    assign s_tready = !m_valid_reg || m_tready;
    assign in_xfer  = s_tvalid && s_tready;

    assign func       = s_tuser;
    assign first_bit  = s_tdata[0];
    assign second_bit = s_tdata[1];
    assign presence   = s_tdata[2];

    // Working code for a new pass: the fork bit is forced to one and every bit
    // above it is cleared. A fork at or above ROM_BITS leaves the code as is.
    always_comb
    begin
        prep_rom = committed_rom_reg;
        if (!committed_fork_reg[FORK_W-1] && (committed_fork_reg < FORK_INIT))
        begin
            for (int i = 0; i < ROM_BITS; i++)
            begin
                if (FORK_W'(i) == committed_fork_reg)
                begin
                    prep_rom[i] = 1'b1;
                end
                else if (FORK_W'(i) > committed_fork_reg)
                begin
                    prep_rom[i] = 1'b0;
                end
            end
        end
    end

    // A zero-zero pair is a fork: repeat a one already in the code, otherwise
    // take zero. A mixed pair names the bit directly.
    assign pick_bit = (!first_bit && !second_bit) ? working_rom_reg[bit_pos_reg] : first_bit;

    assign crc_fb   = crc_reg[0] ^ pick_bit;
    assign crc_step = (crc_reg >> 1) ^ (crc_fb ? CRC_POLY : 8'h00);

    always_comb
    begin
        committed_rom_next  = committed_rom_reg;
        committed_fork_next = committed_fork_reg;
        working_rom_next    = working_rom_reg;
        working_fork_next   = working_fork_reg;
        bit_pos_next        = bit_pos_reg;
        pass_active_next    = pass_active_reg;
        crc_next            = crc_reg;
        drive_next          = 1'b0;
        wbit_next           = 1'b0;
        status_next         = ST_IGNORED;

        case (func)
            FUNC_NEW_SEARCH:
            begin
                committed_rom_next  = '0;
                committed_fork_next = FORK_INIT;
                working_rom_next    = '0;
                working_fork_next   = FORK_INIT;
                bit_pos_next        = '0;
                crc_next            = '0;
                pass_active_next    = 1'b0;
                status_next         = ST_CONTINUE;
            end
            FUNC_START_PASS:
            begin
                bit_pos_next     = '0;
                crc_next         = '0;
                pass_active_next = 1'b0;
                if (committed_fork_reg[FORK_W-1])
                begin
                    // No fork left: the walk has found every device.
                    working_rom_next  = committed_rom_reg;
                    working_fork_next = committed_fork_reg;
                    status_next       = ST_DONE;
                end
                else
                begin
                    working_rom_next  = prep_rom;
                    working_fork_next = FORK_NONE;
                    if (presence)
                    begin
                        pass_active_next = 1'b1;
                        status_next      = ST_CONTINUE;
                    end
                    else
                    begin
                        status_next = ST_NO_PRESENCE;
                    end
                end
            end
            FUNC_BIT_PAIR:
            begin
                if (pass_active_reg)
                begin
                    if (first_bit && second_bit)
                    begin
                        // No device answered on this bit.
                        pass_active_next = 1'b0;
                        status_next      = ST_CONFLICT;
                    end
                    else
                    begin
                        working_rom_next[bit_pos_reg] = pick_bit;
                        if (!first_bit && !second_bit && !pick_bit)
                        begin
                            working_fork_next = FORK_W'(bit_pos_reg);
                        end
                        crc_next     = crc_step;
                        bit_pos_next = bit_pos_reg + 1'b1;
                        drive_next   = 1'b1;
                        wbit_next    = pick_bit;
                        status_next  = ST_CONTINUE;
                        if (bit_pos_reg == LAST_IDX)
                        begin
                            pass_active_next = 1'b0;
                            if (crc_step == 8'h00)
                            begin
                                committed_rom_next  = working_rom_next;
                                committed_fork_next = working_fork_next;
                                status_next         = ST_FOUND;
                            end
                            else
                            begin
                                status_next = ST_CRC_BAD;
                            end
                        end
                    end
                end
            end
            default:
            begin
                status_next = ST_IGNORED;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            committed_rom_reg  <= '0;
            committed_fork_reg <= FORK_INIT;
            working_rom_reg    <= '0;
            working_fork_reg   <= FORK_INIT;
            bit_pos_reg        <= '0;
            pass_active_reg    <= 1'b0;
            crc_reg            <= '0;
            m_valid_reg        <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                committed_rom_reg  <= committed_rom_next;
                committed_fork_reg <= committed_fork_next;
                working_rom_reg    <= working_rom_next;
                working_fork_reg   <= working_fork_next;
                bit_pos_reg        <= bit_pos_next;
                pass_active_reg    <= pass_active_next;
                crc_reg            <= crc_next;
                m_valid_reg        <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload; the code and fork shown are the working copies after the item.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            drive_reg  <= drive_next;
            wbit_reg   <= wbit_next;
            status_reg <= status_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {6'b0, working_fork_reg, ROM_W'(working_rom_reg), wbit_reg, drive_reg};

endmodule

// File: hw/rtl/owrs_checker.sv
module owrs_checker
    import owrs_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [FUNC_W-1:0]   s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [STATUS_W-1:0] m_tuser
);

    // Every input transfer leaves a result in the output register.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("input transfer produced no result");

    // A new search always answers continue without a bus write.
    a_new_search: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == FUNC_NEW_SEARCH)
        |=> (m_tuser == ST_CONTINUE) && !m_tdata[0])
        else $error("new search gave a wrong result");

    // A bus write happens only on bit-pair results that resolved a bit.
    a_write_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0]
        |-> (m_tuser == ST_CONTINUE) || (m_tuser == ST_FOUND) || (m_tuser == ST_CRC_BAD))
        else $error("bus write with a non-write status");

    // Without a write the direction bit is zero.
    a_write_bit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> !m_tdata[1])
        else $error("direction bit set without a bus write");

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind onewire_rom_search_engine_top owrs_checker u_owrs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
